>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/fpgt_pkg.sv
package fpgt_pkg;

    localparam int NSETS = 7;
    localparam int MU_W  = 13;   // 0..4096
    localparam int GAIN_W = 18;

    typedef enum logic [1:0] {
        REG_PROP_FLOOR  = 2'd0,
        REG_PROP_CEIL   = 2'd1,
        REG_DERIV_FLOOR = 2'd2,
        REG_DERIV_CEIL  = 2'd3
    } t_reg_idx;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;     // capture input, clear aggregates
        logic       fuzz;     // compute memberships for set fuzz_idx
        logic [2:0] fuzz_idx;
        logic       infer;    // one rule row/col step
        logic [2:0] row;
        logic [2:0] col;
        logic       sums;     // form num/den for both gains
        logic       div_start;
        logic       div_step;
        logic       commit;   // add and clamp
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;

    // breakpoints: a, b, c
    function automatic logic signed [14:0] err_pt(input logic [2:0] s, input logic [1:0] k);
        logic signed [14:0] v;
        v = '0;
        case (s)
            3'd0: v = (k == 2'd2) ? -15'sd1440 : -15'sd2880;
            3'd1: v = (k == 2'd0) ? -15'sd2880 : (k == 2'd1) ? -15'sd1440 : 15'sd0;
            3'd2: v = (k == 2'd0) ? -15'sd1440 : (k == 2'd1) ? 15'sd0 : 15'sd1440;
            3'd3: v = (k == 2'd0) ? -15'sd320 : (k == 2'd1) ? 15'sd0 : 15'sd320;
            3'd4: v = (k == 2'd0) ? 15'sd0 : (k == 2'd1) ? 15'sd320 : 15'sd640;
            3'd5: v = (k == 2'd0) ? 15'sd320 : (k == 2'd1) ? 15'sd1120 : 15'sd2240;
            3'd6: v = (k == 2'd0) ? 15'sd1440 : 15'sd2880;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [14:0] rate_pt(input logic [2:0] s, input logic [1:0] k);
        logic signed [14:0] v;
        v = '0;
        case (s)
            3'd0: v = (k == 2'd2) ? -15'sd2720 : -15'sd4800;
            3'd1: v = (k == 2'd0) ? -15'sd3800 : (k == 2'd1) ? -15'sd1600 : 15'sd0;
            3'd2: v = (k == 2'd0) ? -15'sd960 : (k == 2'd1) ? -15'sd400 : 15'sd0;
            3'd3: v = (k == 2'd0) ? -15'sd320 : (k == 2'd1) ? 15'sd0 : 15'sd320;
            3'd4: v = (k == 2'd0) ? 15'sd0 : (k == 2'd1) ? 15'sd400 : 15'sd960;
            3'd5: v = (k == 2'd0) ? 15'sd0 : (k == 2'd1) ? 15'sd1600 : 15'sd3800;
            3'd6: v = (k == 2'd0) ? 15'sd2720 : 15'sd4800;
            default: v = '0;
        endcase
        return v;
    endfunction

    // reciprocal (2^24 + span/2) / span, worked out for each span that occurs
    function automatic logic [16:0] span_recip(input logic [13:0] span);
        logic [16:0] r;
        case (span)
            14'd320:  r = 17'd52429;
            14'd400:  r = 17'd41943;
            14'd560:  r = 17'd29959;
            14'd800:  r = 17'd20972;
            14'd1120: r = 17'd14980;
            14'd1440: r = 17'd11651;
            14'd1600: r = 17'd10486;
            14'd2080: r = 17'd8066;
            14'd2200: r = 17'd7626;
            14'd2720: r = 17'd6168;
            default:  r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] prop_rule(input logic [2:0] i, input logic [2:0] j);
        logic [20:0] row;
        case (i)
            3'd0: row = {3'd5, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4, 3'd3};
            3'd1: row = {3'd4, 3'd5, 3'd5, 3'd6, 3'd4, 3'd3, 3'd2};
            3'd2: row = {3'd1, 3'd4, 3'd4, 3'd5, 3'd3, 3'd2, 3'd1};
            3'd3: row = {3'd2, 3'd1, 3'd2, 3'd2, 3'd1, 3'd1, 3'd2};
            3'd4: row = {3'd1, 3'd2, 3'd3, 3'd1, 3'd3, 3'd4, 3'd5};
            3'd5: row = {3'd1, 3'd2, 3'd3, 3'd2, 3'd4, 3'd5, 3'd6};
            3'd6: row = {3'd3, 3'd1, 3'd2, 3'd2, 3'd5, 3'd6, 3'd5};
            default: row = '0;
        endcase
        return row[j*3 +: 3];
    endfunction

    function automatic logic [2:0] deriv_rule(input logic [2:0] i, input logic [2:0] j);
        logic [20:0] row;
        case (i)
            3'd0: row = {3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2};
            3'd1: row = {3'd3, 3'd2, 3'd1, 3'd0, 3'd1, 3'd2, 3'd3};
            3'd2: row = {3'd4, 3'd3, 3'd2, 3'd1, 3'd2, 3'd3, 3'd4};
            3'd3: row = {3'd5, 3'd4, 3'd3, 3'd3, 3'd3, 3'd4, 3'd5};
            3'd4: row = {3'd4, 3'd3, 3'd2, 3'd1, 3'd4, 3'd5, 3'd6};
            3'd5: row = {3'd1, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6};
            3'd6: row = {3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6};
            default: row = '0;
        endcase
        return row[j*3 +: 3];
    endfunction

    function automatic logic signed [3:0] centroid(input logic [2:0] k);
        logic signed [3:0] c;
        case (k)
            3'd0: c = -4'sd5;
            3'd1: c = -4'sd3;
            3'd2: c = -4'sd1;
            3'd3: c = 4'sd0;
            3'd4: c = 4'sd1;
            3'd5: c = 4'sd3;
            3'd6: c = 4'sd5;
            default: c = 4'sd0;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/fpgt_ctrl.sv
module fpgt_ctrl
    import fpgt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE, S_FUZZ, S_INFER, S_SUMS, S_DIV, S_COMMIT, S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_i, n_i;
    logic [2:0] r_j, n_j;
    logic       r_out_valid, n_out_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and command decode
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.fuzz_idx = r_i;
        o_cmd.row   = r_i;
        o_cmd.col   = r_j;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_i        = '0;
                    n_state    = S_FUZZ;
                end
            end
            S_FUZZ: begin
                o_cmd.fuzz = 1'b1;
                if (r_i == 3'(NSETS - 1)) begin
                    n_i = '0;
                    n_j = '0;
                    n_state = S_INFER;
                end else begin
                    n_i = r_i + 3'd1;
                end
            end
            S_INFER: begin
                o_cmd.infer = 1'b1;
                if (r_j == 3'(NSETS - 1)) begin
                    n_j = '0;
                    if (r_i == 3'(NSETS - 1)) begin
                        n_state = S_SUMS;
                    end else begin
                        n_i = r_i + 3'd1;
                    end
                end else begin
                    n_j = r_j + 3'd1;
                end
            end
            S_SUMS: begin
                o_cmd.sums = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_out_valid  = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.div_start = (r_state == S_SUMS);
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/core/fpgt_dp.sv
module fpgt_dp
    import fpgt_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    input  logic signed [12:0]        i_angle_error,
    input  logic signed [13:0]        i_error_rate,
    input  logic [GAIN_W-1:0]         i_pf, i_pc, i_df, i_dc,
    output logic [GAIN_W-1:0]         o_prop_gain,
    output logic [GAIN_W-1:0]         o_deriv_gain
);

    // num magnitude: <= 5*4096*7 < 2^18; shifted by frac bits
    localparam int NUM_W = 18;
    localparam int DEN_W = 16;
    localparam int DVD_W = NUM_W + GAIN_FRAC_BITS + 1;
    localparam int DVS_W = DEN_W + 4;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic signed [13:0] r_e, r_r;
    logic [MU_W-1:0]    r_mu_e [NSETS];
    logic [MU_W-1:0]    r_mu_r [NSETS];
    logic [MU_W-1:0]    r_agg_p [NSETS];
    logic [MU_W-1:0]    r_agg_d [NSETS];

    // triangular membership of x in set given its points
    function automatic logic [MU_W-1:0] tri_mu(input logic signed [14:0] x,
                                               input logic signed [14:0] a,
                                               input logic signed [14:0] b,
                                               input logic signed [14:0] c);
        logic [13:0] offs, span;
        logic [31:0] prod;
        logic [MU_W-1:0] v;
        logic        on_edge, flat;
        offs = '0; span = '0; flat = 1'b0; on_edge = 1'b0;
        if (x >= a && x <= b) begin
            on_edge = 1'b1; flat = (a == b);
            offs = 14'(x - a); span = 14'(b - a);
        end else if (x > b && x <= c) begin
            on_edge = 1'b1; flat = (b == c);
            offs = 14'(c - x); span = 14'(c - b);
        end
        prod = 32'(offs) * 32'(span_recip(span)) + 32'd2048;
        if (!on_edge)              v = '0;
        else if (flat)             v = 13'd4096;
        else if (prod[31:12] > 20'd4096) v = 13'd4096;
        else                       v = prod[24:12];
        return v;
    endfunction

    // one rule per cycle
    logic [MU_W-1:0] w_alpha, w_me, w_mr;
    logic [2:0]      w_kp, w_kd;
    assign w_me    = r_mu_e[i_cmd.col];
    assign w_mr    = r_mu_r[i_cmd.row];
    assign w_alpha = (w_me < w_mr) ? w_me : w_mr;
    assign w_kp    = prop_rule(i_cmd.row, i_cmd.col);
    assign w_kd    = deriv_rule(i_cmd.row, i_cmd.col);

    // input capture on load, membership one set per cycle, max aggregation on infer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_e <= 14'(i_angle_error);
            r_r <= i_error_rate;
            for (int k = 0; k < NSETS; k++) begin
                r_agg_p[k] <= '0;
                r_agg_d[k] <= '0;
            end
        end
        if (i_cmd.fuzz) begin
            r_mu_e[i_cmd.fuzz_idx] <= tri_mu(15'(r_e), err_pt(i_cmd.fuzz_idx, 2'd0),
                err_pt(i_cmd.fuzz_idx, 2'd1), err_pt(i_cmd.fuzz_idx, 2'd2));
            r_mu_r[i_cmd.fuzz_idx] <= tri_mu(15'(r_r), rate_pt(i_cmd.fuzz_idx, 2'd0),
                rate_pt(i_cmd.fuzz_idx, 2'd1), rate_pt(i_cmd.fuzz_idx, 2'd2));
        end
        if (i_cmd.infer) begin
            if (w_alpha > r_agg_p[w_kp]) r_agg_p[w_kp] <= w_alpha;
            if (w_alpha > r_agg_d[w_kd]) r_agg_d[w_kd] <= w_alpha;
        end
    end

    // centroid sums over seven aggregates
    logic signed [NUM_W+1:0] w_num_p, w_num_d;
    logic [DEN_W-1:0]        w_den_p, w_den_d;
    always_comb begin
        w_num_p = '0; w_num_d = '0; w_den_p = '0; w_den_d = '0;
        for (int k = 0; k < NSETS; k++) begin
            w_num_p = w_num_p + (NUM_W+2)'($signed({1'b0, r_agg_p[k]})) * centroid(3'(k));
            w_num_d = w_num_d + (NUM_W+2)'($signed({1'b0, r_agg_d[k]})) * centroid(3'(k));
            w_den_p = w_den_p + DEN_W'(r_agg_p[k]);
            w_den_d = w_den_d + DEN_W'(r_agg_d[k]);
        end
    end

    // two restoring dividers stepping together
    logic [DVD_W-1:0] r_q_p, r_q_d;
    logic [DVS_W:0]   r_rem_p, r_rem_d;
    logic [DVS_W-1:0] r_dv_p, r_dv_d;
    logic             r_neg_p, r_neg_d;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W:0]   w_tp, w_td;

    assign w_tp = {r_rem_p[DVS_W-1:0], r_q_p[DVD_W-1]};
    assign w_td = {r_rem_d[DVS_W-1:0], r_q_d[DVD_W-1]};
    assign o_sts.div_done = (r_cnt == '0);

    function automatic logic [DVD_W-1:0] dividend(input logic signed [NUM_W+1:0] n,
                                                   input logic [DEN_W-1:0] d);
        logic [NUM_W-1:0] mag;
        mag = n[NUM_W+1] ? NUM_W'(-n) : NUM_W'(n);
        return (DVD_W'(mag) << GAIN_FRAC_BITS) + DVD_W'(5 * 32'(d));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_cnt <= CNT_W'(DVD_W);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.div_start) begin
            r_q_p   <= dividend(w_num_p, w_den_p);
            r_q_d   <= dividend(w_num_d, w_den_d);
            r_dv_p  <= DVS_W'(w_den_p) * DVS_W'(10);
            r_dv_d  <= DVS_W'(w_den_d) * DVS_W'(10);
            r_neg_p <= w_num_p[NUM_W+1];
            r_neg_d <= w_num_d[NUM_W+1];
            r_rem_p <= '0;
            r_rem_d <= '0;
        end else if (i_cmd.div_step) begin
            if (w_tp >= {1'b0, r_dv_p}) begin
                r_rem_p <= w_tp - {1'b0, r_dv_p};
                r_q_p   <= {r_q_p[DVD_W-2:0], 1'b1};
            end else begin
                r_rem_p <= w_tp;
                r_q_p   <= {r_q_p[DVD_W-2:0], 1'b0};
            end
            if (w_td >= {1'b0, r_dv_d}) begin
                r_rem_d <= w_td - {1'b0, r_dv_d};
                r_q_d   <= {r_q_d[DVD_W-2:0], 1'b1};
            end else begin
                r_rem_d <= w_td;
                r_q_d   <= {r_q_d[DVD_W-2:0], 1'b0};
            end
        end
    end

    // add increment and clamp: ceiling first, then floor
    function automatic logic [GAIN_W-1:0] clamp(input logic [GAIN_W-1:0] acc,
                                                input logic [DVD_W-1:0] q,
                                                input logic neg, input logic zero,
                                                input logic [GAIN_W-1:0] lo,
                                                input logic [GAIN_W-1:0] hi);
        logic signed [DVD_W+2:0] v;
        v = $signed((DVD_W+3)'(acc));
        if (!zero) v = neg ? v - $signed((DVD_W+3)'(q)) : v + $signed((DVD_W+3)'(q));
        if (v > $signed((DVD_W+3)'(hi))) v = $signed((DVD_W+3)'(hi));
        if (v < $signed((DVD_W+3)'(lo))) v = $signed((DVD_W+3)'(lo));
        return v[GAIN_W-1:0];
    endfunction

    logic [GAIN_W-1:0] r_kp, r_kd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0;
            r_kd <= '0;
        end else if (i_cmd.commit) begin
            r_kp <= clamp(r_kp, r_q_p, r_neg_p, r_dv_p == '0, i_pf, i_pc);
            r_kd <= clamp(r_kd, r_q_d, r_neg_d, r_dv_d == '0, i_df, i_dc);
        end
    end

    assign o_prop_gain  = r_kp;
    assign o_deriv_gain = r_kd;

endmodule

>>> rtl/core/fuzzy_pd_gain_tuner_core.sv
// Fuzzy self-tuning PD gain core.
// Input channel: i_in_valid / o_in_stall carry i_angle_error (Q.4 deg) and
// i_error_rate (Q.2). Output channel: o_out_valid / i_out_stall carry the
// updated, clamped o_prop_gain and o_deriv_gain (Q.GAIN_FRAC_BITS).
// One item is in flight at a time. After a transfer the core runs
// fuzzification (one set per cycle) and min-max inference (one rule a cycle),
// forms the centroid sums, runs the two shift-subtract dividers side by side
// (one step per dividend bit, then a check that sees the count run out), and
// finally adds and clamps before it shows the result.
// The result holds while i_out_stall is high; a new input is taken the cycle
// after the result transfer.
// Config writes (i_cfg_we, i_cfg_idx, i_cfg_wdata) take effect at once and
// must be made only while idle; the core does not enforce this. All four
// i_cfg_idx values select a limit register.
// Reset (synchronous, active low) clears both gains, restores clamp limits
// (25.0 and 10.0 ceilings, zero floors) and empties the pipeline.
`include "assert_macros.svh"
module fuzzy_pd_gain_tuner_core
    import fpgt_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [12:0]   i_angle_error,
    input  logic signed [13:0]   i_error_rate,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [GAIN_W-1:0]    o_prop_gain,
    output logic [GAIN_W-1:0]    o_deriv_gain,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [GAIN_W-1:0]    i_cfg_wdata
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic [GAIN_W-1:0] r_pf, r_pc, r_df, r_dc;

    // clamp limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pf <= '0;
            r_pc <= GAIN_W'(102400);
            r_df <= '0;
            r_dc <= GAIN_W'(40960);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_PROP_FLOOR:  r_pf <= i_cfg_wdata;
                REG_PROP_CEIL:   r_pc <= i_cfg_wdata;
                REG_DERIV_FLOOR: r_df <= i_cfg_wdata;
                REG_DERIV_CEIL:  r_dc <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    fpgt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall,
        .o_cmd(w_cmd), .i_sts(w_sts)
    );

    fpgt_dp #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts),
        .i_angle_error, .i_error_rate,
        .i_pf(r_pf), .i_pc(r_pc), .i_df(r_df), .i_dc(r_dc),
        .o_prop_gain, .o_deriv_gain
    );

    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_prop_gain) && $stable(o_deriv_gain))
    `ASSERT_IMPL(a_cmd_excl, i_clk, i_rst_n, 1'b1,
        $onehot0({w_cmd.load, w_cmd.fuzz, w_cmd.infer, w_cmd.div_step, w_cmd.commit}))

endmodule
